### hdl/assert_macros.svh
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold whenever the reset is released
`define CHK_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on the following clock edge
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/pee_pkg.sv
package pee_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 64;
	localparam int unsigned DATA_W = 32;

	localparam logic [7:0] SYM_ZERO  = 8'h30;
	localparam logic [7:0] SYM_NINE  = 8'h39;
	localparam logic [7:0] SYM_PLUS  = 8'h2B;
	localparam logic [7:0] SYM_MINUS = 8'h2D;
	localparam logic [7:0] SYM_MUL   = 8'h2A;
	localparam logic [7:0] SYM_DIV   = 8'h2F;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_UNDER   = 2'd1,
		ST_DIVZERO = 2'd2,
		ST_OVER    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		OP_PUSH,
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_DROP
	} op_t;

	// controller -> datapath commands
	typedef struct packed {
		logic     rd_top;    // read top two entries into operand regs
		logic     rd_out;    // read top entry for the result
		logic     exec;      // compute / start divide
		logic     div_step;  // one divider iteration
		logic     write;     // write result and update depth
		logic     clear;     // reset depth and error
		op_t      op;
		logic [3:0] digit;
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic push_ok;    // stack has room
		logic pop_ok;     // at least two entries
		logic empty;
		logic div_done;
		logic div_zero;
	} stat_t;

endpackage

### hdl/pee_if.sv
interface pee_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       final_req;
	modport source (output valid, symbol, final_req, input ready);
	modport sink (input valid, symbol, final_req, output ready);
endinterface

interface pee_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic [1:0]         status;
	modport source (output valid, value, status, input ready);
	modport sink (input valid, value, status, output ready);
endinterface

### hdl/pee_datapath.sv
module pee_datapath import pee_pkg::*; #(
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       stat,
	output logic [31:0] top_q,
	output logic [1:0]  err_q,
	input  logic        flag_en,
	input  status_t     flag_code
);
	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

	logic [31:0] mem [STACK_DEPTH];
	logic [DW-1:0] depth_q;
	logic [31:0] a_q, b_q, res_q;
	logic [31:0] rem_q, quo_q, div_q;
	logic [5:0]  cnt_q;
	logic        neg_q;

	// stack pointers
	logic [AW-1:0] idx1, idx2, widx;
	assign idx1 = AW'(depth_q - DW'(1));
	assign idx2 = AW'(depth_q - DW'(2));
	assign widx = AW'(depth_q);

	assign stat.push_ok  = depth_q < DW'(STACK_DEPTH);
	assign stat.pop_ok   = depth_q >= DW'(2);
	assign stat.empty    = depth_q == '0;
	assign stat.div_done = cnt_q == '0;
	assign stat.div_zero = b_q == '0;

	// operand reads, registered
	always_ff @(posedge clk) begin
		if (cmd.rd_top) begin
			a_q <= mem[idx1];
			b_q <= mem[idx2];
		end else if (cmd.rd_out) begin
			a_q <= mem[idx1];
		end
	end
	assign top_q = a_q;

	// magnitude and sign for divider
	logic [31:0] ma, mb, rem_sh, quo_sh;
	logic [32:0] trial;
	assign ma = a_q[31] ? (32'd0 - a_q) : a_q;
	assign mb = b_q[31] ? (32'd0 - b_q) : b_q;
	assign rem_sh = {rem_q[30:0], div_q[31]};
	assign trial = {1'b0, rem_sh} - {1'b0, mb};
	assign quo_sh = {quo_q[30:0], !trial[32]};

	// arithmetic and restoring divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.exec && cmd.op == OP_DIV) begin
			cnt_q <= 6'd32;
		end else if (cmd.div_step && cnt_q != '0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			case (cmd.op)
				OP_ADD:  res_q <= a_q + b_q;
				OP_SUB:  res_q <= a_q - b_q;
				OP_MUL:  res_q <= a_q * b_q;
				OP_PUSH: res_q <= {28'd0, cmd.digit};
				default: res_q <= '0;
			endcase
			div_q <= ma;
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= a_q[31] ^ b_q[31];
		end else if (cmd.div_step && cnt_q != '0) begin
			div_q <= {div_q[30:0], 1'b0};
			if (!trial[32]) begin
				rem_q <= trial[31:0];
			end else begin
				rem_q <= rem_sh;
			end
			quo_q <= quo_sh;
			if (cnt_q == 6'd1) begin
				res_q <= (b_q == '0) ? 32'd0 : (neg_q ? (32'd0 - quo_sh) : quo_sh);
			end
		end
	end

	// stack write and depth
	always_ff @(posedge clk) begin
		if (cmd.write) begin
			if (cmd.op == OP_PUSH) begin
				mem[widx] <= res_q;
			end else begin
				mem[idx2] <= res_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			err_q   <= ST_OK;
		end else begin
			if (cmd.clear) begin
				depth_q <= '0;
			end else if (cmd.write) begin
				case (cmd.op)
					OP_PUSH: depth_q <= depth_q + DW'(1);
					OP_DROP: depth_q <= depth_q - DW'(2);
					default: depth_q <= depth_q - DW'(1);
				endcase
			end
			if (cmd.clear) begin
				err_q <= ST_OK;
			end else if (flag_en && err_q == ST_OK) begin
				err_q <= flag_code;
			end
		end
	end

endmodule

### hdl/pee_ctrl.sv
module pee_ctrl import pee_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	pee_in_if.sink      in_ch,
	output cmd_t        cmd,
	input  stat_t       stat,
	output logic        flag_en,
	output status_t     flag_code,
	input  logic        out_full,
	output logic        busy
);
	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_EXEC, S_DIV, S_WRITE, S_OUTRD, S_OUT
	} state_t;

	state_t state_q;
	logic [7:0] sym_q;
	logic fin_q;
	op_t op_q;

	op_t dec_op;
	logic is_digit;
	always_comb begin
		is_digit = sym_q >= SYM_ZERO && sym_q <= SYM_NINE;
		case (sym_q)
			SYM_PLUS:  dec_op = OP_ADD;
			SYM_MINUS: dec_op = OP_SUB;
			SYM_MUL:   dec_op = OP_MUL;
			SYM_DIV:   dec_op = OP_DIV;
			default:   dec_op = OP_DROP;
		endcase
		if (is_digit) dec_op = OP_PUSH;
	end

	assign in_ch.ready = state_q == S_IDLE;
	assign busy = state_q != S_IDLE;

	// command decode
	always_comb begin
		cmd = '0;
		cmd.op = op_q;
		cmd.digit = 4'(sym_q - SYM_ZERO);
		flag_en = 1'b0;
		flag_code = ST_OK;
		case (state_q)
			S_READ: begin
				cmd.op = dec_op;
				if (dec_op == OP_PUSH) begin
					cmd.exec = stat.push_ok;
					flag_en = !stat.push_ok;
					flag_code = ST_OVER;
				end else begin
					cmd.rd_top = stat.pop_ok;
					flag_en = !stat.pop_ok;
					flag_code = ST_UNDER;
				end
			end
			S_EXEC:  cmd.exec = 1'b1;
			S_DIV: begin
				cmd.div_step = 1'b1;
				flag_en = stat.div_done && stat.div_zero;
				flag_code = ST_DIVZERO;
			end
			S_WRITE: cmd.write = 1'b1;
			S_OUTRD: cmd.rd_out = !stat.empty;
			S_OUT: begin
				cmd.clear = 1'b1;
				flag_en = stat.empty;
				flag_code = ST_UNDER;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sym_q <= '0;
			fin_q <= 1'b0;
			op_q <= OP_PUSH;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						sym_q <= in_ch.symbol;
						fin_q <= in_ch.final_req;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					op_q <= dec_op;
					if (dec_op == OP_PUSH) begin
						state_q <= stat.push_ok ? S_WRITE : (fin_q ? S_OUTRD : S_IDLE);
					end else if (!stat.pop_ok) begin
						state_q <= fin_q ? S_OUTRD : S_IDLE;
					end else begin
						state_q <= (dec_op == OP_DROP) ? S_WRITE : S_EXEC;
					end
				end
				S_EXEC: state_q <= (op_q == OP_DIV) ? S_DIV : S_WRITE;
				S_DIV:  if (stat.div_done) state_q <= S_WRITE;
				S_WRITE: state_q <= fin_q ? S_OUTRD : S_IDLE;
				// hold until the previous result has left the output register
				S_OUTRD: if (!out_full) state_q <= S_OUT;
				S_OUT: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### hdl/prefix_expression_evaluator.sv
// Prefix expression evaluator. Feed the expression's characters from last to
// first, one transaction each, with final_req set on the first character; that
// transaction yields one result (top of stack, status) and clears the stack.
// After an accepted transaction a digit passes through READ and WRITE; +, - and
// * through READ, EXEC and WRITE; other symbols, which drop two entries, through
// READ and WRITE; a symbol that over- or underflows ends in READ; and / through
// READ, EXEC, DIV and WRITE, DIV being a restoring divider that retires one
// quotient bit per cycle. A final item adds OUTRD and OUT, plus any wait while
// the previous result still sits unread in the output register. The next item
// is taken once the previous one is done. The stack holds STACK_DEPTH 32-bit
// entries in a memory with one write port.
`include "assert_macros.svh"
module prefix_expression_evaluator import pee_pkg::*; #(
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
	input logic      clk,
	input logic      arst_n,
	pee_in_if.sink   in_ch,
	pee_out_if.source out_ch
);
	cmd_t cmd;
	stat_t stat;
	logic flag_en;
	status_t flag_code;
	logic [31:0] top_q;
	logic [1:0] err_q;
	logic busy;
	logic out_valid_q;
	logic [31:0] out_value_q;
	logic [1:0] out_status_q;

	pee_ctrl u_ctrl (
		.clk, .arst_n, .in_ch, .cmd, .stat, .flag_en, .flag_code,
		.out_full(out_valid_q), .busy
	);

	pee_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
		.clk, .arst_n, .cmd, .stat, .top_q, .err_q, .flag_en, .flag_code
	);

	// output register: capture on stack clear, release on transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_status_q <= '0;
		end else begin
			if (cmd.clear) begin
				out_valid_q <= 1'b1;
				out_status_q <= (err_q == ST_OK && stat.empty) ? 2'(ST_UNDER) : err_q;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.clear) out_value_q <= stat.empty ? 32'd0 : top_q;
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.value = out_value_q;
	assign out_ch.status = out_status_q;

	`CHK_ALWAYS(a_no_accept_busy, clk, arst_n, !(in_ch.ready && busy), "ready while busy")
	`CHK_NEXT(a_clear_gives_out, clk, arst_n, cmd.clear, out_ch.valid, "result missing")
	`CHK_ALWAYS(a_one_cmd, clk, arst_n, $onehot0({cmd.exec, cmd.write, cmd.clear}), "commands overlap")
	`CHK_NEXT(a_out_hold, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid, "result dropped")
endmodule

### sim/prefix_expression_evaluator_tb.sv
`timescale 1ns / 1ps
module prefix_expression_evaluator_tb;
	import pee_pkg::*;

	localparam int DEPTH = STACK_DEPTH_DEF;
	localparam int AW = $clog2(DEPTH);
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [7:0] symbol;
		logic       final_req;
	} sym_item_t;

	typedef struct packed {
		logic [31:0] value;
		status_t     status;
	} eval_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pee_in_if in_ch ();
	pee_out_if out_ch ();

	prefix_expression_evaluator uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [31:0] eval_stack [DEPTH];
	int          eval_depth = 0;
	status_t     eval_error = ST_OK;

	sym_item_t    pending_syms [$];
	eval_result_t expected_results [$];

	int  send_idle_pct = 21;
	int  recv_idle_pct = 62;
	bit  recv_hold = 1'b0;
	bit  send_pause = 1'b0;
	int  errors = 0;
	int  idle_cycles = 0;

	function automatic logic [31:0] trunc_div(logic [31:0] a, logic [31:0] b);
		logic [31:0] ma, mb, q;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		if (a[31] ^ b[31])
			q = -q;
		return q;
	endfunction

	function automatic void note_error(status_t code);
		if (eval_error == ST_OK)
			eval_error = code;
	endfunction

	// advance the evaluation model by one symbol
	function automatic void eval_symbol(sym_item_t it);
		logic [31:0] a, b, r;
		eval_result_t res;
		if (it.symbol >= SYM_ZERO && it.symbol <= SYM_NINE) begin
			if (eval_depth >= DEPTH)
				note_error(ST_OVER);
			else begin
				eval_stack[AW'(eval_depth)] = 32'(it.symbol - SYM_ZERO);
				eval_depth++;
			end
		end else if (eval_depth < 2) begin
			note_error(ST_UNDER);
		end else begin
			a = eval_stack[AW'(eval_depth - 1)];
			b = eval_stack[AW'(eval_depth - 2)];
			eval_depth -= 2;
			r = 32'd0;
			case (it.symbol)
				SYM_PLUS: r = a + b;
				SYM_MINUS: r = a - b;
				SYM_MUL: r = a * b;
				SYM_DIV: begin
					if (b == 32'd0)
						note_error(ST_DIVZERO);
					else
						r = trunc_div(a, b);
				end
				default: ;
			endcase
			if (it.symbol inside {SYM_PLUS, SYM_MINUS, SYM_MUL, SYM_DIV}) begin
				eval_stack[AW'(eval_depth)] = r;
				eval_depth++;
			end
		end
		if (it.final_req) begin
			res.status = eval_error;
			res.value = 32'd0;
			if (eval_depth >= 1)
				res.value = eval_stack[AW'(eval_depth - 1)];
			else if (res.status == ST_OK)
				res.status = ST_UNDER;
			expected_results.push_back(res);
			eval_depth = 0;
			eval_error = ST_OK;
		end
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.symbol <= 8'd0;
			in_ch.final_req <= 1'b0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (in_ch.valid)
				eval_symbol({in_ch.symbol, in_ch.final_req});
			if (pending_syms.size() > 0 && !send_pause &&
					$urandom_range(99) >= send_idle_pct) begin
				in_ch.valid <= 1'b1;
				{in_ch.symbol, in_ch.final_req} <= pending_syms.pop_front();
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// monitor and receiver
	always @(posedge clk or negedge arst_n) begin
		eval_result_t exp_r;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result value=%0d status=%0d",
						out_ch.value, out_ch.status);
					errors++;
				end else begin
					exp_r = expected_results.pop_front();
					if (out_ch.value !== exp_r.value) begin
						$error("value: expected %0d actual %0d",
							$signed(exp_r.value), out_ch.value);
						errors++;
					end
					if (out_ch.status !== exp_r.status) begin
						$error("status: expected %0d actual %0d",
							exp_r.status, out_ch.status);
						errors++;
					end
				end
			end
			if (recv_hold) begin
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("prefix_expression_evaluator: mismatch");
			$finish;
		end
	end

	task automatic push_sym(logic [7:0] s, logic f);
		pending_syms.push_back({s, f});
	endtask

	function automatic logic [7:0] rand_digit();
		return SYM_ZERO + 8'($urandom_range(9));
	endfunction

	function automatic logic [7:0] rand_op();
		case ($urandom_range(3))
			0: return SYM_PLUS;
			1: return SYM_MINUS;
			2: return SYM_MUL;
			default: return SYM_DIV;
		endcase
	endfunction

	// well-formed prefix expression, emitted last char first
	task automatic gen_expression(int n_ops);
		logic [7:0] chars [$];
		int need;
		need = 1;
		while (need > 0) begin
			if (n_ops > 0 && $urandom_range(1)) begin
				chars.push_back(rand_op());
				n_ops--;
				need++;
			end else begin
				chars.push_back(rand_digit());
				need--;
			end
		end
		for (int i = chars.size() - 1; i >= 0; i--)
			push_sym(chars[i], i == 0);
	endtask

	task automatic gen_noise(int n);
		for (int i = 0; i < n; i++)
			push_sym(8'($urandom_range(255)), i == n - 1);
	endtask

	task automatic drain();
		wait (pending_syms.size() == 0);
		@(posedge clk);
		while (in_ch.valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic random_phase(int n_items);
		int start;
		start = pending_syms.size();
		while (pending_syms.size() - start < n_items) begin
			case ($urandom_range(9))
				0: gen_noise($urandom_range(1, 8));
				1: begin
					// broken: missing operands
					push_sym(rand_digit(), 1'b0);
					push_sym(rand_op(), 1'b0);
					push_sym(rand_op(), 1'b1);
				end
				default: gen_expression($urandom_range(0, 10));
			endcase
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: each operator
		push_sym("3", 1'b0); push_sym("7", 1'b0); push_sym(SYM_PLUS, 1'b1);
		push_sym("3", 1'b0); push_sym("7", 1'b0); push_sym(SYM_MINUS, 1'b1);
		push_sym("9", 1'b0); push_sym("9", 1'b0); push_sym(SYM_MUL, 1'b1);
		push_sym("2", 1'b0); push_sym("7", 1'b0); push_sym(SYM_DIV, 1'b1);
		// divide by zero, then a later underflow keeps the first error
		push_sym("0", 1'b0); push_sym("5", 1'b0); push_sym(SYM_DIV, 1'b0);
		push_sym(SYM_PLUS, 1'b1);
		// empty stack at the end, leftover entries, unknown symbol drop
		push_sym(8'hFF, 1'b1);
		push_sym("1", 1'b0); push_sym("2", 1'b1);
		push_sym("1", 1'b0); push_sym("2", 1'b0); push_sym(8'h00, 1'b0);
		push_sym("4", 1'b1);
		push_sym(8'hC5, 1'b0); push_sym(8'h5A, 1'b1);
		drain();

		// most negative over minus one: 0-1 = -1, build -2^31 via 2^31 wrap
		push_sym("1", 1'b0); push_sym("0", 1'b0); push_sym(SYM_MINUS, 1'b0); // -1
		push_sym("2", 1'b0);
		for (int i = 0; i < 30; i++) begin
			push_sym("2", 1'b0); push_sym(SYM_MUL, 1'b0);
		end
		push_sym("0", 1'b0); push_sym(SYM_MINUS, 1'b0);   // 0 - 2^31 wraps
		push_sym(SYM_DIV, 1'b1);                          // (-2^31) / -1
		// overflow: fill past the stack
		for (int i = 0; i <= DEPTH + 1; i++)
			push_sym(rand_digit(), i == DEPTH + 1);
		drain();

		// long receiver hold-off while the sender keeps going
		recv_hold = 1'b1;
		fork
			begin
				repeat (3000) @(posedge clk);
				recv_hold = 1'b0;
			end
		join_none
		random_phase(250);
		drain();

		// sender pauses mid-stream until everything is back
		random_phase(40);
		wait (pending_syms.size() < 20);
		send_pause = 1'b1;
		@(posedge clk);
		while (in_ch.valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		send_pause = 1'b0;
		drain();

		send_idle_pct = 62;
		recv_idle_pct = 21;
		random_phase(250);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(250);
		drain();

		if (errors == 0 && expected_results.size() == 0)
			$display("prefix_expression_evaluator: match");
		else
			$display("prefix_expression_evaluator: mismatch");
		$finish;
	end
endmodule

### files.f
+incdir+hdl
hdl/pee_pkg.sv
hdl/pee_if.sv
hdl/pee_datapath.sv
hdl/pee_ctrl.sv
hdl/prefix_expression_evaluator.sv
sim/prefix_expression_evaluator_tb.sv
